[hdl/lcgs_pkg.sv]
// Shared types and constants for the line color gradient stepper.
// No dependencies; used by every module under hdl/.
`default_nettype none

package lcgs_pkg;

  localparam int CHAN_BITS = 8;
  localparam logic [CHAN_BITS-1:0] CHAN_MAX = 8'd255;

  // bit offsets of the channels in a packed RGBA word
  localparam int RED_LSB   = 24;
  localparam int GREEN_LSB = 16;
  localparam int BLUE_LSB  = 8;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_STEP = 1'b1;

  typedef enum logic {
    ST_IDLE,
    ST_DIV
  } state_t;

  // divider lane controls, driven by the top level sequencer
  typedef struct packed {
    logic start;  // capture channel pair and clear partial quotient
    logic run;    // retire one quotient bit
    logic last;   // final quotient bit, commit the signed step
  } div_ctrl_t;

endpackage

`default_nettype wire

[hdl/lcgs_div_lane.sv]
// One color channel's bit-serial restoring divider and its step register.
// Depends on lcgs_pkg for the control struct and channel width.
`default_nettype none

module lcgs_div_lane #(
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 16
) (
  input  wire                                      clk,
  input  wire                                      rst,
  input  lcgs_pkg::div_ctrl_t                      ctrl,
  input  wire        [COORD_BITS-1:0]              divisor,
  input  wire        [lcgs_pkg::CHAN_BITS-1:0]     start_chan,
  input  wire        [lcgs_pkg::CHAN_BITS-1:0]     end_chan,
  output logic       [lcgs_pkg::CHAN_BITS+FRAC_BITS:0] step
);

  localparam int CW = lcgs_pkg::CHAN_BITS;
  localparam int QW = CW + FRAC_BITS;

  logic [CW-1:0]         dvd;    // dividend magnitude, MSB first then zeros
  logic [COORD_BITS-1:0] rem;
  logic [QW-1:0]         quo;
  logic                  neg;

  logic                  neg_in;
  logic [CW-1:0]         mag_in;
  logic [COORD_BITS:0]   trial;
  logic                  ge;
  logic [COORD_BITS:0]   diff;
  logic [QW-1:0]         quo_next;
  logic [QW:0]           quo_ext;

  always_comb begin
    neg_in   = end_chan < start_chan;
    mag_in   = neg_in ? (start_chan - end_chan) : (end_chan - start_chan);
    trial    = {rem, dvd[CW-1]};
    ge       = trial >= {1'b0, divisor};
    diff     = trial - {1'b0, divisor};
    quo_next = {quo[QW-2:0], ge};
    quo_ext  = {1'b0, quo_next};
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      dvd <= mag_in;
      rem <= '0;
      quo <= '0;
      neg <= neg_in;
    end else if (ctrl.run) begin
      dvd <= {dvd[CW-2:0], 1'b0};
      rem <= ge ? diff[COORD_BITS-1:0] : trial[COORD_BITS-1:0];
      quo <= quo_next;
    end
  end

  // step is architectural state: zero after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      step <= '0;
    end else if (ctrl.last) begin
      step <= neg ? ((QW+1)'(0) - quo_ext) : quo_ext;
    end
  end

endmodule

`default_nettype wire

[hdl/lcgs_chan_adv.sv]
// Advances one channel by its fixed-point step: round half up, clamp to 0..255.
// Depends on lcgs_pkg for the channel width and limit.
`default_nettype none

module lcgs_chan_adv #(
  parameter int FRAC_BITS = 16
) (
  input  wire  [lcgs_pkg::CHAN_BITS-1:0]           chan,
  input  wire  [lcgs_pkg::CHAN_BITS+FRAC_BITS:0]   step,
  output logic [lcgs_pkg::CHAN_BITS-1:0]           chan_next
);

  localparam int CW = lcgs_pkg::CHAN_BITS;
  localparam int SW = CW + FRAC_BITS + 2;
  localparam logic [SW-1:0] HALF = SW'(1) << (FRAC_BITS - 1);

  logic [SW-1:0] sum;
  logic [CW:0]   whole;

  always_comb begin
    // two's complement sum; MSB set means negative
    sum   = {2'b00, chan, {FRAC_BITS{1'b0}}} + {step[CW+FRAC_BITS], step} + HALF;
    whole = sum[SW-2:FRAC_BITS];
    if (sum[SW-1]) begin
      chan_next = '0;
    end else if (whole > {1'b0, lcgs_pkg::CHAN_MAX}) begin
      chan_next = lcgs_pkg::CHAN_MAX;
    end else begin
      chan_next = whole[CW-1:0];
    end
  end

endmodule

`default_nettype wire

[hdl/line_color_gradient_stepper_top.sv]
// Line color gradient stepper, top level. Uses lcgs_pkg, lcgs_div_lane, lcgs_chan_adv.
// Step word: result the cycle after accept, one step word per cycle while the output is not stalled.
// Load word: result (start color) the cycle after accept; then the three divider
// lanes retire one quotient bit per cycle, and input stalls until the last quotient bit.
// Reset (rst, synchronous) clears color and steps to zero and empties the output.
`default_nettype none

module line_color_gradient_stepper_top #(
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 16
) (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   in_valid,
  output logic                  in_stall,
  input  wire                   operation,
  input  wire  [31:0]           start_color,
  input  wire  [31:0]           end_color,
  input  wire  [COORD_BITS-1:0] delta_x,
  input  wire  [COORD_BITS-1:0] delta_y,
  output logic                  out_valid,
  input  wire                   out_stall,
  output logic [31:0]           pixel_color
);

  localparam int CW    = lcgs_pkg::CHAN_BITS;
  localparam int QW    = CW + FRAC_BITS;
  localparam int CNT_W = $clog2(QW);

  lcgs_pkg::state_t    state, state_next;
  lcgs_pkg::div_ctrl_t ctrl;

  logic [CNT_W-1:0]      cnt;
  logic [COORD_BITS-1:0] steps;
  logic [COORD_BITS-1:0] steps_max;
  logic                  in_acc;
  logic                  out_valid_next;
  logic [31:0]           color_step;

  logic [QW:0]           red_step, green_step, blue_step;
  logic [CW-1:0]         red_next, green_next, blue_next;

  always_comb begin
    state_next = state;
    in_stall   = !(state == lcgs_pkg::ST_IDLE && (!out_valid || !out_stall));
    in_acc     = in_valid && !in_stall;
    ctrl.start = in_acc && operation == lcgs_pkg::OP_LOAD;
    ctrl.run   = state == lcgs_pkg::ST_DIV;
    ctrl.last  = ctrl.run && cnt == '0;
    unique case (state)
      lcgs_pkg::ST_IDLE: begin
        if (ctrl.start) state_next = lcgs_pkg::ST_DIV;
      end
      lcgs_pkg::ST_DIV: begin
        if (ctrl.last) state_next = lcgs_pkg::ST_IDLE;
      end
      default: state_next = lcgs_pkg::ST_IDLE;
    endcase
    if (in_acc) begin
      out_valid_next = 1'b1;
    end else begin
      out_valid_next = out_valid && out_stall;
    end
    steps_max = (delta_x > delta_y) ? delta_x : delta_y;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= lcgs_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      cnt   <= CNT_W'(QW - 1);
      steps <= (steps_max == '0) ? COORD_BITS'(1) : steps_max;
    end else if (ctrl.run) begin
      cnt <= cnt - CNT_W'(1);
    end
  end

  // current color doubles as the output word; it only moves when the slot frees
  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_color <= '0;
    end else if (in_acc) begin
      pixel_color <= (operation == lcgs_pkg::OP_LOAD) ? start_color : color_step;
    end
  end

  lcgs_div_lane #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_div_red (
    .clk(clk), .rst(rst), .ctrl(ctrl), .divisor(steps),
    .start_chan(start_color[lcgs_pkg::RED_LSB +: CW]),
    .end_chan(end_color[lcgs_pkg::RED_LSB +: CW]),
    .step(red_step)
  );

  lcgs_div_lane #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_div_green (
    .clk(clk), .rst(rst), .ctrl(ctrl), .divisor(steps),
    .start_chan(start_color[lcgs_pkg::GREEN_LSB +: CW]),
    .end_chan(end_color[lcgs_pkg::GREEN_LSB +: CW]),
    .step(green_step)
  );

  lcgs_div_lane #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_div_blue (
    .clk(clk), .rst(rst), .ctrl(ctrl), .divisor(steps),
    .start_chan(start_color[lcgs_pkg::BLUE_LSB +: CW]),
    .end_chan(end_color[lcgs_pkg::BLUE_LSB +: CW]),
    .step(blue_step)
  );

  lcgs_chan_adv #(.FRAC_BITS(FRAC_BITS)) u_adv_red (
    .chan(pixel_color[lcgs_pkg::RED_LSB +: CW]), .step(red_step), .chan_next(red_next)
  );

  lcgs_chan_adv #(.FRAC_BITS(FRAC_BITS)) u_adv_green (
    .chan(pixel_color[lcgs_pkg::GREEN_LSB +: CW]), .step(green_step), .chan_next(green_next)
  );

  lcgs_chan_adv #(.FRAC_BITS(FRAC_BITS)) u_adv_blue (
    .chan(pixel_color[lcgs_pkg::BLUE_LSB +: CW]), .step(blue_step), .chan_next(blue_next)
  );

  assign color_step = {red_next, green_next, blue_next, pixel_color[CW-1:0]};

endmodule

`default_nettype wire

[bench/testbench.sv]
`timescale 1ns / 100ps
// Self-checking bench for line_color_gradient_stepper_top: directed and random words,
// predicted colors checked in order. Depends on lcgs_pkg and the top level only.
module testbench;

  localparam int COORD    = 12;
  localparam int FRAC     = 16;
  localparam int SLOPE_W  = FRAC + 9;
  localparam int WORDS    = 1200;
  localparam int LIMIT    = 200000;
  localparam int TAIL     = 8 + FRAC + 16;

  typedef enum logic [1:0] {
    RX_READY,
    RX_LIGHT,
    RX_HEAVY,
    RX_PERIODIC
  } rx_mode_t;

  logic             clk         = 1'b0;
  logic             rst         = 1'b1;
  logic             in_valid    = 1'b0;
  logic             in_stall;
  logic             operation   = lcgs_pkg::OP_LOAD;
  logic [31:0]      start_color = '0;
  logic [31:0]      end_color   = '0;
  logic [COORD-1:0] delta_x     = '0;
  logic [COORD-1:0] delta_y     = '0;
  logic             out_valid;
  logic             out_stall   = 1'b0;
  logic [31:0]      pixel_color;

  // predicted gradient state
  logic [31:0]               grad_color = '0;
  logic signed [SLOPE_W-1:0] grad_slope [3];

  logic [31:0] want_colors [$];
  int          words_sent  = 0;
  int          err_count   = 0;
  int          cycle_count = 0;
  int          burst_left  = 0;
  int          gap_max     = 0;
  int          hold_req    = 0;
  bit          valid_low   = 1'b1;
  rx_mode_t    rx_mode     = RX_READY;

  line_color_gradient_stepper_top #(
    .COORD_BITS(COORD),
    .FRAC_BITS (FRAC)
  ) u_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .operation  (operation),
    .start_color(start_color),
    .end_color  (end_color),
    .delta_x    (delta_x),
    .delta_y    (delta_y),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .pixel_color(pixel_color)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == LIMIT) begin
      $display("[line_color_gradient_stepper_top] ERROR");
      $finish;
    end
  end

  function automatic int chan_lsb(int k);
    case (k)
      0:       return lcgs_pkg::RED_LSB;
      1:       return lcgs_pkg::GREEN_LSB;
      default: return lcgs_pkg::BLUE_LSB;
    endcase
  endfunction

  // (to - from) / span in fixed point, truncated toward zero
  function automatic logic signed [SLOPE_W-1:0] chan_slope(logic [7:0] from, logic [7:0] to,
                                                           int span);
    longint mag;
    longint q;
    mag = (to >= from) ? longint'(to) - longint'(from) : longint'(from) - longint'(to);
    q = (mag << FRAC) / span;
    return (to < from) ? SLOPE_W'(-q) : SLOPE_W'(q);
  endfunction

  // round half up, clamp to 0..255
  function automatic logic [7:0] chan_next(logic [7:0] ch, logic signed [SLOPE_W-1:0] slope);
    longint acc;
    acc = (longint'(ch) << FRAC) + longint'(slope) + (longint'(1) << (FRAC - 1));
    if (acc < 0) return 8'd0;
    acc = acc >>> FRAC;
    if (acc > 255) return lcgs_pkg::CHAN_MAX;
    return acc[7:0];
  endfunction

  function automatic logic [31:0] gradient_next(logic op, logic [31:0] s, logic [31:0] e,
                                                logic [COORD-1:0] dx, logic [COORD-1:0] dy);
    int span;
    int k;
    if (op == lcgs_pkg::OP_LOAD) begin
      span = (dx > dy) ? int'(dx) : int'(dy);
      if (span == 0) span = 1;
      for (k = 0; k < 3; k++)
        grad_slope[k] = chan_slope(s[chan_lsb(k) +: 8], e[chan_lsb(k) +: 8], span);
      grad_color = s;
    end else begin
      for (k = 0; k < 3; k++)
        grad_color[chan_lsb(k) +: 8] = chan_next(grad_color[chan_lsb(k) +: 8], grad_slope[k]);
    end
    return grad_color;
  endfunction

  function automatic logic [31:0] pick_color();
    logic [31:0] c;
    int k;
    for (k = 0; k < 4; k++) begin
      case ($urandom_range(0, 5))
        0:       c[8*k +: 8] = 8'h00;
        1:       c[8*k +: 8] = 8'hFF;
        default: c[8*k +: 8] = 8'($urandom);
      endcase
    end
    return c;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
    err_count++;
    if (err_count <= 30)
      $display("mismatch %s at cycle %0d: expected %08h got %08h", what, cycle_count, want,
               got);
  endtask

  task automatic send_word(logic op, logic [31:0] s, logic [31:0] e,
                           logic [COORD-1:0] dx, logic [COORD-1:0] dy);
    int pause;
    in_valid    <= 1'b1;
    valid_low   = 1'b0;
    operation   <= op;
    start_color <= s;
    end_color   <= e;
    delta_x     <= dx;
    delta_y     <= dy;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    want_colors.push_back(gradient_next(op, s, e, dx, dy));
    words_sent++;
    if (gap_max > 0) begin
      if (burst_left == 0) begin
        pause = $urandom_range(1, gap_max);
        in_valid    <= 1'b0;
        valid_low   = 1'b1;
        operation   <= 1'($urandom);
        start_color <= $urandom;
        end_color   <= $urandom;
        delta_x     <= COORD'($urandom);
        delta_y     <= COORD'($urandom);
        repeat (pause) @(posedge clk);
        burst_left = $urandom_range(1, 24);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic send_step();
    send_word(lcgs_pkg::OP_STEP, $urandom, $urandom, COORD'($urandom), COORD'($urandom));
  endtask

  // receiver: long hold-off on request, otherwise the current stall pattern
  always @(posedge clk) begin : rx_side
    int hold_left;
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      case (rx_mode)
        RX_READY:    out_stall <= 1'b0;
        RX_LIGHT:    out_stall <= ($urandom_range(0, 3) == 0);
        RX_HEAVY:    out_stall <= ($urandom_range(0, 2) != 0);
        RX_PERIODIC: out_stall <= ((cycle_count % 7) < 3);
      endcase
    end
  end

  always @(posedge clk) begin : color_check
    logic [31:0] want;
    if (!rst && out_valid && !out_stall) begin
      if (want_colors.size() == 0) begin
        report_mismatch("unexpected word", 32'h0, pixel_color);
      end else begin
        want = want_colors.pop_front();
        if (pixel_color !== want) report_mismatch("pixel_color", want, pixel_color);
      end
    end
  end

  task automatic test_step_from_reset();
    send_step();
    send_step();
  endtask

  task automatic test_zero_length();
    send_word(lcgs_pkg::OP_LOAD, 32'hFFFF_FFFF, 32'h0000_0000, '0, '0);
    send_step();
    send_step();
    send_word(lcgs_pkg::OP_LOAD, 32'h0000_00A5, 32'hFFFF_FF00, '0, '0);
    send_step();
    send_step();
  endtask

  task automatic test_extreme_deltas();
    send_word(lcgs_pkg::OP_LOAD, 32'h00FF_0011, 32'hFF00_FF22, 12'hFFF, 12'h000);
    send_step();
    send_step();
    send_word(lcgs_pkg::OP_LOAD, 32'hFF00_FF33, 32'h00FF_0044, 12'h000, 12'hFFF);
    send_step();
    send_word(lcgs_pkg::OP_LOAD, 32'h8040_C0FF, 32'h40C0_8000, 12'hFFF, 12'hFFF);
    send_step();
    send_word(lcgs_pkg::OP_LOAD, 32'h1020_3040, 32'hF0E0_D0C0, 12'h001, 12'hFFE);
    send_step();
  endtask

  // half-way increments round up; runs past either end clamp
  task automatic test_rounding_clamp();
    send_word(lcgs_pkg::OP_LOAD, 32'h0001_FE5A, 32'h0100_FF00, 12'd2, 12'd1);
    send_step();
    send_step();
    send_word(lcgs_pkg::OP_LOAD, 32'h01FE_0077, 32'h00FF_FF00, 12'd1, 12'd0);
    send_step();
    send_step();
    send_step();
  endtask

  // receiver holds off while the sender keeps offering words
  task automatic test_backpressure();
    int k;
    rx_mode  = RX_READY;
    gap_max  = 0;
    hold_req = 300;
    send_word(lcgs_pkg::OP_LOAD, pick_color(), pick_color(), COORD'($urandom_range(0, 63)),
              COORD'($urandom_range(0, 63)));
    for (k = 0; k < 60; k++) send_step();
    send_word(lcgs_pkg::OP_LOAD, pick_color(), pick_color(), COORD'($urandom_range(0, 15)),
              COORD'($urandom_range(0, 15)));
    for (k = 0; k < 40; k++) send_step();
  endtask

  task automatic test_random_lines(int target);
    int next_shuffle;
    int n_steps;
    int span;
    int k;
    logic [COORD-1:0] dx;
    logic [COORD-1:0] dy;
    next_shuffle = words_sent;
    while (words_sent < target) begin
      if (words_sent >= next_shuffle) begin
        rx_mode      = rx_mode_t'($urandom_range(0, 3));
        gap_max      = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        burst_left   = $urandom_range(0, 24);
        next_shuffle = words_sent + 100;
      end
      if ($urandom_range(0, 6) == 0) begin
        send_word(1'($urandom), $urandom, $urandom, COORD'($urandom), COORD'($urandom));
      end else begin
        case ($urandom_range(0, 9))
          0: begin
            dx = COORD'($urandom);
            dy = COORD'($urandom);
          end
          1, 2: begin
            dx = COORD'($urandom_range(0, 255));
            dy = COORD'($urandom_range(0, 255));
          end
          default: begin
            dx = COORD'($urandom_range(0, 15));
            dy = COORD'($urandom_range(0, 15));
          end
        endcase
        send_word(lcgs_pkg::OP_LOAD, pick_color(), pick_color(), dx, dy);
        span = (dx > dy) ? int'(dx) : int'(dy);
        n_steps = $urandom_range(0, (span < 20) ? span + 1 : 20);
        for (k = 0; k < n_steps; k++) send_step();
      end
    end
  endtask

  initial begin
    grad_slope[0] = '0;
    grad_slope[1] = '0;
    grad_slope[2] = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_step_from_reset();
    test_zero_length();
    test_extreme_deltas();
    test_rounding_clamp();
    test_backpressure();
    test_random_lines(WORDS);
    if (!valid_low) in_valid <= 1'b0;
    while (want_colors.size() != 0) @(posedge clk);
    repeat (TAIL) @(posedge clk);
    if (err_count == 0)
      $display("[line_color_gradient_stepper_top] OK");
    else
      $display("[line_color_gradient_stepper_top] ERROR");
    $finish;
  end

endmodule
